FILE: design/ppr_pkg.sv
// ppr_pkg: shared constants and codes for the polyphase plane resampler.
// Store depths, derived widths, command codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package ppr_pkg;

    // Store depths and filter size
    localparam int SRC_DEPTH   = 4096;
    localparam int OUT_ENTRIES = 256;
    localparam int MAX_TAPS    = 8;
    localparam int COEFF_DEPTH = 2048;

    // Derived index widths
    localparam int SRC_AW  = $clog2(SRC_DEPTH);
    localparam int OUT_AW  = $clog2(OUT_ENTRIES);
    localparam int COEF_AW = $clog2(COEFF_DEPTH);
    localparam int TAP_W   = $clog2(MAX_TAPS + 1);
    localparam int CI_W    = $clog2(OUT_ENTRIES * MAX_TAPS) + 1;

    // Running source address: (4095 + MAX_TAPS) * 4095 + 4095 fits in 26 bits
    localparam int ADDR_W = 26;

    // Fixed-point filter arithmetic, Q2.14 coefficients
    localparam int FRAC_BITS  = 14;
    localparam int ROUND_BIAS = 1 << (FRAC_BITS - 1);
    localparam int PROD_W     = 33;
    localparam int ACC_W      = PROD_W + $clog2(MAX_TAPS) + 2;

    // Command codes carried in s_tuser
    localparam logic [1:0] CMD_WR_SAMPLE = 2'd0;
    localparam logic [1:0] CMD_WR_OFFSET = 2'd1;
    localparam logic [1:0] CMD_WR_COEFF  = 2'd2;
    localparam logic [1:0] CMD_COMPUTE   = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_HORIZ_MODE  = 3'd0;
    localparam logic [2:0] REG_TAP_COUNT   = 3'd1;
    localparam logic [2:0] REG_SRC_PITCH   = 3'd2;
    localparam logic [2:0] REG_LANE_COUNT  = 3'd3;
    localparam logic [2:0] REG_CLAMP_LIMIT = 3'd4;
    localparam logic [2:0] REG_POINT_MODE  = 3'd5;

endpackage

`default_nettype wire

FILE: design/polyphase_plane_resampler.sv
// Writes are taken in ST_IDLE; a compute passes ST_BASE, ST_TAP and ST_DRAIN before m_tvalid,
// ST_TAP walking n taps (one in point mode; an output entry past the table skips to ST_DRAIN)
// one tap per cycle over the source and coefficient memory read ports.
// Throughput: one transaction at a time; the next is accepted once the previous one has
// loaded the output register, which may still be waiting on m_tready.
// Reset: aresetn (synchronous, active low) restores register defaults and control state.
`timescale 1ns / 1ps
`default_nettype none

module polyphase_plane_resampler import ppr_pkg::*; (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [2:0]  cfg_addr,
    input  wire logic [15:0] cfg_wdata,
    // input stream
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // s_tdata, low bit up: table_address[11:0], sample_value[27:12],
    // offset_value[39:28], coeff_value[55:40], out_row[63:56],
    // out_col[75:64], lane[77:76], zero fill[79:78]
    input  wire logic [79:0] s_tdata,
    // s_tuser: command[1:0]
    input  wire logic [1:0]  s_tuser,
    // result stream
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // m_tdata: pixel_value[15:0]
    output logic [15:0]      m_tdata,
    // m_tuser: range_error[0]
    output logic [0:0]       m_tuser
);

    typedef enum logic [3:0] {
        ST_IDLE  = 4'b0001,
        ST_BASE  = 4'b0010,
        ST_TAP   = 4'b0100,
        ST_DRAIN = 4'b1000
    } state_t;

    // Configuration registers
    logic        horiz_reg;
    logic [3:0]  tap_count_reg;
    logic [11:0] pitch_reg;
    logic [2:0]  lane_count_reg;
    logic [15:0] clamp_reg;
    logic        point_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            horiz_reg      <= 1'b0;
            tap_count_reg  <= 4'd1;
            pitch_reg      <= 12'd0;
            lane_count_reg <= 3'd1;
            clamp_reg      <= 16'd255;
            point_reg      <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_HORIZ_MODE:  horiz_reg      <= cfg_wdata[0];
                REG_TAP_COUNT:   tap_count_reg  <= cfg_wdata[3:0];
                REG_SRC_PITCH:   pitch_reg      <= cfg_wdata[11:0];
                REG_LANE_COUNT:  lane_count_reg <= cfg_wdata[2:0];
                REG_CLAMP_LIMIT: clamp_reg      <= cfg_wdata[15:0];
                REG_POINT_MODE:  point_reg      <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // Input field unpacking
    logic [1:0]         in_cmd;
    logic [11:0]        in_tbl_addr;
    logic [15:0]        in_sample;
    logic [11:0]        in_offset;
    logic signed [15:0] in_coeff;
    logic [7:0]         in_row;
    logic [11:0]        in_col;
    logic [1:0]         in_lane;

    assign in_cmd      = s_tuser;
    assign in_tbl_addr = s_tdata[11:0];
    assign in_sample   = s_tdata[27:12];
    assign in_offset   = s_tdata[39:28];
    assign in_coeff    = s_tdata[55:40];
    assign in_row      = s_tdata[63:56];
    assign in_col      = s_tdata[75:64];
    assign in_lane     = s_tdata[77:76];

    // Effective tap and lane counts after saturation
    logic [4:0]       tc_ext;
    logic [TAP_W-1:0] taps_eff;
    logic [2:0]       lanes_eff;

    always_comb begin
        tc_ext = {1'b0, tap_count_reg};
        if (tc_ext > 5'(MAX_TAPS)) begin
            taps_eff = TAP_W'(MAX_TAPS);
        end else begin
            taps_eff = TAP_W'(tc_ext);
        end
        if (lane_count_reg == 3'd0) begin
            lanes_eff = 3'd1;
        end else if (lane_count_reg > 3'd4) begin
            lanes_eff = 3'd4;
        end else begin
            lanes_eff = lane_count_reg;
        end
    end

    state_t state_reg, state_next;

    logic accept;
    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;

    // Write decode with range checks
    logic [31:0] tbl_addr_ext;
    logic        src_we, offs_we, coef_we;

    assign tbl_addr_ext = 32'(in_tbl_addr);
    assign src_we  = accept && (in_cmd == CMD_WR_SAMPLE) && (tbl_addr_ext < 32'(SRC_DEPTH));
    assign offs_we = accept && (in_cmd == CMD_WR_OFFSET) && (tbl_addr_ext < 32'(OUT_ENTRIES));
    assign coef_we = accept && (in_cmd == CMD_WR_COEFF) && (tbl_addr_ext < 32'(COEFF_DEPTH));

    // Output-entry select for a compute transaction
    logic [11:0]     sel;
    logic [31:0]     sel_ext;
    logic            sel_bad;
    logic [CI_W-1:0] ci_start;

    assign sel      = horiz_reg ? in_col : {4'd0, in_row};
    assign sel_ext  = 32'(sel);
    assign sel_bad  = (sel_ext >= 32'(OUT_ENTRIES));
    assign ci_start = CI_W'(sel_ext[OUT_AW-1:0]) * CI_W'(taps_eff);

    // Running tap address, coefficient index and tap counter
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CI_W-1:0]   ci_reg, ci_next;
    logic [TAP_W-1:0]  tap_left_reg, tap_left_next;
    logic [11:0]       col_reg;
    logic [1:0]        lane_reg;
    logic [19:0]       row_pitch_reg;
    logic              err_reg, err_next;

    // Memories
    logic [15:0]        src_mem  [SRC_DEPTH];
    logic [11:0]        offs_mem [OUT_ENTRIES];
    logic signed [15:0] coef_mem [COEFF_DEPTH];

    logic [15:0]        src_q;
    logic [11:0]        offs_q;
    logic signed [15:0] coef_q;

    logic [31:0] src_rd_ext, ci_rd_ext;
    logic        rd_issue;

    assign src_rd_ext = 32'(addr_reg);
    assign ci_rd_ext  = 32'(ci_reg);

    always_ff @(posedge aclk) begin
        if (src_we) begin
            src_mem[tbl_addr_ext[SRC_AW-1:0]] <= in_sample;
        end
        src_q <= src_mem[src_rd_ext[SRC_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (offs_we) begin
            offs_mem[tbl_addr_ext[OUT_AW-1:0]] <= in_offset;
        end
        offs_q <= offs_mem[sel_ext[OUT_AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (coef_we) begin
            coef_mem[tbl_addr_ext[COEF_AW-1:0]] <= in_coeff;
        end
        coef_q <= coef_mem[ci_rd_ext[COEF_AW-1:0]];
    end

    // First tap address from the offset read
    logic [23:0]       base_mul;
    logic [ADDR_W-1:0] addr_first;
    logic [ADDR_W-1:0] addr_step;
    logic              tap_bad;

    assign base_mul   = offs_q * (horiz_reg ? {9'd0, lanes_eff} : pitch_reg);
    assign addr_first = horiz_reg
                      ? ADDR_W'(base_mul) + ADDR_W'(lane_reg) + ADDR_W'(row_pitch_reg)
                      : ADDR_W'(base_mul) + ADDR_W'(col_reg);
    assign addr_step  = horiz_reg ? ADDR_W'(lanes_eff) : ADDR_W'(pitch_reg);
    assign tap_bad    = (addr_reg >= ADDR_W'(SRC_DEPTH))
                     || (!point_reg && (ci_rd_ext >= 32'(COEFF_DEPTH)));

    // MAC pipeline flags
    logic rd_vld_reg, prod_vld_reg;
    logic pipe_empty;
    assign pipe_empty = !rd_vld_reg && !prod_vld_reg;

    // Output register handshake
    logic out_vld_reg;
    logic out_free;
    logic out_load;
    assign out_free = !out_vld_reg || m_tready;
    assign out_load = (state_reg == ST_DRAIN) && pipe_empty && out_free;

    // Sequencer
    always_comb begin
        state_next    = state_reg;
        addr_next     = addr_reg;
        ci_next       = ci_reg;
        tap_left_next = tap_left_reg;
        err_next      = err_reg;
        rd_issue      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (accept && (in_cmd == CMD_COMPUTE)) begin
                    err_next      = sel_bad;
                    ci_next       = ci_start;
                    tap_left_next = '0;
                    state_next    = sel_bad ? ST_DRAIN : ST_BASE;
                end
            end
            ST_BASE: begin
                addr_next     = addr_first;
                tap_left_next = point_reg ? TAP_W'(1) : taps_eff;
                state_next    = ST_TAP;
            end
            ST_TAP: begin
                if (tap_left_reg == '0) begin
                    state_next = ST_DRAIN;
                end else if (tap_bad) begin
                    err_next   = 1'b1;
                    state_next = ST_DRAIN;
                end else begin
                    rd_issue      = 1'b1;
                    addr_next     = addr_reg + addr_step;
                    ci_next       = ci_reg + CI_W'(1);
                    tap_left_next = tap_left_reg - TAP_W'(1);
                end
            end
            ST_DRAIN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            tap_left_reg <= '0;
            err_reg      <= 1'b0;
        end else begin
            state_reg    <= state_next;
            tap_left_reg <= tap_left_next;
            err_reg      <= err_next;
        end
    end

    // Per-transaction payload registers
    always_ff @(posedge aclk) begin
        addr_reg <= addr_next;
        ci_reg   <= ci_next;
        if (accept) begin
            col_reg       <= in_col;
            lane_reg      <= in_lane;
            row_pitch_reg <= in_row * pitch_reg;
        end
    end

    // Multiply stage, then accumulate stage
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [15:0]              samp_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rd_vld_reg   <= 1'b0;
            prod_vld_reg <= 1'b0;
        end else begin
            rd_vld_reg   <= rd_issue;
            prod_vld_reg <= rd_vld_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            prod_reg <= coef_q * $signed({1'b0, src_q});
            samp_reg <= src_q;
        end
        if (accept) begin
            acc_reg <= ACC_W'(ROUND_BIAS);
        end else if (prod_vld_reg) begin
            acc_reg <= acc_reg + ACC_W'(prod_reg);
        end
    end

    // Round, clamp and select the result
    logic signed [ACC_W-1:0] acc_shift;
    logic [15:0]             pixel_calc;

    assign acc_shift = acc_reg >>> FRAC_BITS;

    always_comb begin
        if (err_reg) begin
            pixel_calc = 16'd0;
        end else if (point_reg) begin
            pixel_calc = samp_reg;
        end else if (acc_reg < 0) begin
            pixel_calc = 16'd0;
        end else if (acc_shift > $signed(ACC_W'(clamp_reg))) begin
            pixel_calc = clamp_reg;
        end else begin
            pixel_calc = acc_shift[15:0];
        end
    end

    // Output register
    logic [15:0] pixel_reg;
    logic        range_err_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_vld_reg <= 1'b0;
        end else if (out_load) begin
            out_vld_reg <= 1'b1;
        end else if (m_tready) begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            pixel_reg     <= pixel_calc;
            range_err_reg <= err_reg;
        end
    end

    assign m_tvalid   = out_vld_reg;
    assign m_tdata    = pixel_reg;
    assign m_tuser[0] = range_err_reg;

endmodule

`default_nettype wire
